// ----- hw/rtl/hrc_pkg.sv -----
package hrc_pkg;

    // Default sizing of the ring
    localparam int DEPTH_DEF       = 16;
    localparam int ENTRY_WIDTH_DEF = 32;

    // Width of the request code on the input channel
    localparam int FUNC_WIDTH = 3;

    // Request codes as they arrive on the input channel
    localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH  = 3'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_OLDER = 3'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_NEWER = 3'd2;
    localparam logic [FUNC_WIDTH-1:0] FUNC_RSTC  = 3'd3;
    localparam logic [FUNC_WIDTH-1:0] FUNC_CLEAR = 3'd4;
    localparam logic [FUNC_WIDTH-1:0] FUNC_DUMP  = 3'd5;

    // Classified operation carried through the command queue
    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_OLDER = 3'd1,
        OP_NEWER = 3'd2,
        OP_RSTC  = 3'd3,
        OP_CLEAR = 3'd4,
        OP_DUMP  = 3'd5,
        OP_NOP   = 3'd6
    } t_op;

    localparam int OP_WIDTH = $bits(t_op);

    // Result status codes
    typedef enum logic [1:0] {
        ST_ENTRY  = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_NEWEST = 2'd2,
        ST_ACK    = 2'd3
    } t_status;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DUMP = 3'b100
    } t_state;

endpackage

// ----- hw/rtl/history_ring_with_cursor_top.sv -----
// Path: a transaction passes the front hold register and the command queue to the executor.
// Push, cursor reset, clear and empty or at-newest answers load the result register from
// idle; older/newer reads and each dump entry first pass the registered memory read.
// Throughput: one transaction per cycle for those while the output is not stalled; no new
// command is taken during a read or dump, and a dump reads its entries one at a time.
// Reset: synchronous, active low; clears pointers, fill count and valids; entries not cleared.
module history_ring_with_cursor_top #(
    parameter int DEPTH       = hrc_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = hrc_pkg::ENTRY_WIDTH_DEF,
    parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [hrc_pkg::FUNC_WIDTH-1:0] i_func,
    input  logic [ENTRY_WIDTH-1:0]         i_entry_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_status,
    output logic [ENTRY_WIDTH-1:0]         o_entry_out,
    output logic [COUNT_WIDTH-1:0]         o_count,
    output logic                           o_last
);
    import hrc_pkg::*;

    localparam int QW = ENTRY_WIDTH + OP_WIDTH;

    logic                   f_valid;
    logic                   q_ready;
    t_op                    f_op;
    logic [ENTRY_WIDTH-1:0] f_word;
    logic                   q_valid;
    logic                   q_pop;
    logic [QW-1:0]          q_data;
    t_op                    q_op;

    // Front end: accept and classify
    hrc_front #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_func     (i_func),
        .i_entry_in (i_entry_in),
        .o_valid    (f_valid),
        .i_ready    (q_ready),
        .o_op       (f_op),
        .o_word     (f_word)
    );

    // Command queue
    hrc_queue #(
        .DATA_WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_data  ({f_op, f_word}),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    assign q_op = t_op'(q_data[QW-1 -: OP_WIDTH]);

    // Back end: ring state, memory and result register
    hrc_back #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_op      (q_op),
        .i_q_word    (q_data[ENTRY_WIDTH-1:0]),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_entry_out (o_entry_out),
        .o_count     (o_count),
        .o_last      (o_last)
    );

endmodule

// ----- hw/rtl/hrc_front.sv -----
module hrc_front #(
    parameter int ENTRY_WIDTH = hrc_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [hrc_pkg::FUNC_WIDTH-1:0] i_func,
    input  logic [ENTRY_WIDTH-1:0]        i_entry_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output hrc_pkg::t_op                  o_op,
    output logic [ENTRY_WIDTH-1:0]        o_word
);
    import hrc_pkg::*;

    logic                   r_valid;
    t_op                    r_op;
    logic [ENTRY_WIDTH-1:0] r_word;
    t_op                    op_dec;
    logic                   accept;

    // Classify the request code; unused codes become a no-op
    always_comb begin
        unique case (i_func)
            FUNC_PUSH:  op_dec = OP_PUSH;
            FUNC_OLDER: op_dec = OP_OLDER;
            FUNC_NEWER: op_dec = OP_NEWER;
            FUNC_RSTC:  op_dec = OP_RSTC;
            FUNC_CLEAR: op_dec = OP_CLEAR;
            FUNC_DUMP:  op_dec = OP_DUMP;
            default:    op_dec = OP_NOP;
        endcase
    end

    // Hold stage in front of the queue
    assign o_stall = r_valid && !i_ready;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= op_dec;
            r_word <= i_entry_in;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_word  = r_word;

endmodule

// ----- hw/rtl/hrc_queue.sv -----
module hrc_queue #(
    parameter int DATA_WIDTH = hrc_pkg::ENTRY_WIDTH_DEF + hrc_pkg::OP_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_ready,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  logic                  i_pop,
    output logic [DATA_WIDTH-1:0] o_data
);
    // Two-entry command queue between classifier and executor
    logic [DATA_WIDTH-1:0] r_slot [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/hrc_back.sv -----
module hrc_back #(
    parameter int DEPTH       = hrc_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = hrc_pkg::ENTRY_WIDTH_DEF,
    parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  hrc_pkg::t_op           i_q_op,
    input  logic [ENTRY_WIDTH-1:0] i_q_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [ENTRY_WIDTH-1:0] o_entry_out,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_last
);
    import hrc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0]          LAST_IDX = PW'(DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] FULL_CNT = COUNT_WIDTH'(DEPTH);
    localparam logic [COUNT_WIDTH-1:0] ONE_CNT  = COUNT_WIDTH'(1);

    function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] p);
        return (p == '0) ? LAST_IDX : p - PW'(1);
    endfunction

    // Ring state
    t_state                 r_state, n_state;
    logic [PW-1:0]          r_head, n_head;
    logic [PW-1:0]          r_tail, n_tail;
    logic [PW-1:0]          r_cur, n_cur;
    logic                   r_at_head, n_at_head;
    logic [COUNT_WIDTH-1:0] r_fill, n_fill;
    logic [PW-1:0]          r_dptr, n_dptr;
    logic [COUNT_WIDTH-1:0] r_left, n_left;
    logic                   r_dump, n_dump;

    // Entry memory
    logic [ENTRY_WIDTH-1:0] mem [DEPTH];
    logic [ENTRY_WIDTH-1:0] r_rd;
    logic                   rd_en;
    logic [PW-1:0]          rd_addr;
    logic                   wr_en;

    // Output register
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [ENTRY_WIDTH-1:0] r_out_entry;
    logic [COUNT_WIDTH-1:0] r_out_count;
    logic                   r_out_last;

    logic                   out_free;
    logic                   ld;
    t_status                ld_status;
    logic [ENTRY_WIDTH-1:0] ld_entry;
    logic                   ld_last;
    logic                   pop;

    assign out_free = !r_out_valid || !i_out_stall;

    // Executor: one command from the queue at a time
    always_comb begin
        logic [PW-1:0] c;
        c         = r_cur;
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_cur     = r_cur;
        n_at_head = r_at_head;
        n_fill    = r_fill;
        n_dptr    = r_dptr;
        n_left    = r_left;
        n_dump    = r_dump;
        rd_en     = 1'b0;
        rd_addr   = r_dptr;
        wr_en     = 1'b0;
        pop       = 1'b0;
        ld        = 1'b0;
        ld_status = ST_ACK;
        ld_entry  = '0;
        ld_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    pop = 1'b1;
                    unique case (i_q_op)
                        OP_PUSH: begin
                            wr_en = 1'b1;
                            if (r_fill == FULL_CNT) begin
                                n_tail = ring_inc(r_tail);
                            end else begin
                                n_fill = r_fill + ONE_CNT;
                            end
                            n_head    = ring_inc(r_head);
                            n_cur     = ring_inc(r_head);
                            n_at_head = 1'b1;
                            ld        = 1'b1;
                        end
                        OP_OLDER: begin
                            if (r_fill == '0) begin
                                ld        = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                if (r_at_head) begin
                                    c = ring_dec(r_head);
                                end else if (r_cur != r_tail) begin
                                    c = ring_dec(r_cur);
                                end
                                n_cur     = c;
                                n_at_head = 1'b0;
                                rd_en     = 1'b1;
                                rd_addr   = c;
                                n_dump    = 1'b0;
                                n_state   = S_READ;
                            end
                        end
                        OP_NEWER: begin
                            c = ring_inc(r_cur);
                            if (r_fill == '0) begin
                                ld        = 1'b1;
                                ld_status = ST_EMPTY;
                            end else if (r_at_head) begin
                                ld        = 1'b1;
                                ld_status = ST_NEWEST;
                            end else if (c == r_head) begin
                                n_cur     = c;
                                n_at_head = 1'b1;
                                ld        = 1'b1;
                                ld_status = ST_NEWEST;
                            end else begin
                                n_cur   = c;
                                rd_en   = 1'b1;
                                rd_addr = c;
                                n_dump  = 1'b0;
                                n_state = S_READ;
                            end
                        end
                        OP_RSTC: begin
                            n_cur     = r_head;
                            n_at_head = 1'b1;
                            ld        = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_head    = '0;
                            n_tail    = '0;
                            n_cur     = '0;
                            n_fill    = '0;
                            n_at_head = 1'b1;
                            ld        = 1'b1;
                        end
                        OP_DUMP: begin
                            if (r_fill == '0) begin
                                ld        = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                n_dptr  = r_tail;
                                n_left  = r_fill;
                                n_dump  = 1'b1;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                rd_en   = 1'b1;
                rd_addr = r_dptr;
                n_state = S_READ;
            end
            S_READ: begin
                if (out_free) begin
                    ld        = 1'b1;
                    ld_status = ST_ENTRY;
                    ld_entry  = r_rd;
                    ld_last   = !r_dump || (r_left == ONE_CNT);
                    if (r_dump && (r_left != ONE_CNT)) begin
                        n_left  = r_left - ONE_CNT;
                        n_dptr  = ring_inc(r_dptr);
                        n_state = S_DUMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_cur     <= '0;
            r_at_head <= 1'b1;
            r_fill    <= '0;
            r_dptr    <= '0;
            r_left    <= '0;
            r_dump    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_cur     <= n_cur;
            r_at_head <= n_at_head;
            r_fill    <= n_fill;
            r_dptr    <= n_dptr;
            r_left    <= n_left;
            r_dump    <= n_dump;
        end
    end

    // Entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_head] <= i_q_word;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out_status <= ld_status;
            r_out_entry  <= ld_entry;
            r_out_count  <= n_fill;
            r_out_last   <= ld_last;
        end
    end

    assign o_q_pop     = pop;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_entry_out = r_out_entry;
    assign o_count     = r_out_count;
    assign o_last      = r_out_last;

endmodule
